### rtl/tsd_pkg.sv
// Shared types and constants for the temperature sensor scratchpad decoder.
// No dependencies; used by tsd_frame, tsd_result and the top level.
package tsd_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned TempW = 16;
  localparam int unsigned PosW  = 4;

  // Scratchpad byte positions
  localparam logic [PosW-1:0] PosTempLo      = 4'd0;
  localparam logic [PosW-1:0] PosTempHi      = 4'd1;
  localparam logic [PosW-1:0] PosResolution  = 4'd4;
  localparam logic [PosW-1:0] PosCountRemain = 4'd6;
  localparam logic [PosW-1:0] PosCountPerDeg = 4'd7;
  localparam logic [PosW-1:0] PosCrc         = 4'd8;

  // Captured frame contents handed from the frame tracker to the result stage
  typedef struct packed {
    logic [ByteW-1:0] crc;
    logic [ByteW-1:0] temp_lo;
    logic [ByteW-1:0] temp_hi;
    logic [ByteW-1:0] resolution;
    logic [ByteW-1:0] count_remain;
    logic [ByteW-1:0] count_per_degree;
  } tsd_frame_t;

endpackage

### rtl/temp_sensor_scratchpad_decoder.sv
// Top level of the temperature sensor scratchpad decoder: input register,
// family code register and handshake. Depends on tsd_pkg, tsd_frame, tsd_result.

// Takes one scratchpad byte per transfer on the slave stream (data byte in
// tdata, frame start flag in tuser) and sustains one byte per clock cycle.
// A byte is held in the input register, where the CRC-8 update and field
// capture run; when it is byte 8 the CRC check and temperature conversion
// load the result register from it, and the result is offered on the master
// stream from the result register until it is taken.
// Throughput is set by the combinational byte CRC update; the only stall is a
// final byte meeting a full result register that is not being taken.
// family_code (reset 0x28) is written through cfg_wr_en_i/cfg_wr_data_i
// while the block is idle, a rule for the user that the block does not enforce;
// code 0x10 selects the nine-bit conversion.
module temp_sensor_scratchpad_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_wr_en_i,
  input  logic [7:0]  cfg_wr_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tuser,   // [0] frame_start
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [15:0] temperature_sixteenths, [23:16] computed_crc
  output logic        m_axis_tuser    // [0] crc_ok
);
  import tsd_pkg::*;

  localparam logic [ByteW-1:0] FamilyReset = 8'h28;

  logic             in_valid_q;
  logic [ByteW-1:0] in_byte_q;
  logic             in_start_q;
  logic [ByteW-1:0] family_q;
  logic             is_final;
  logic             slot_free;
  logic             advance;
  logic             load;
  tsd_frame_t       frame;
  logic [TempW-1:0] temp;
  logic             crc_ok;
  logic [ByteW-1:0] crc;

  // the held byte moves on unless it needs a result slot that is busy
  assign advance       = in_valid_q && (!is_final || slot_free);
  assign load          = advance && is_final;
  assign s_axis_tready = !in_valid_q || advance;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q  <= s_axis_tdata;
      in_start_q <= s_axis_tuser;
    end
  end

  // family code register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      family_q <= FamilyReset;
    end else if (cfg_wr_en_i) begin
      family_q <= cfg_wr_data_i;
    end
  end

  tsd_frame u_frame (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (advance),
    .byte_i  (in_byte_q),
    .start_i (in_start_q),
    .final_o (is_final),
    .frame_o (frame)
  );

  tsd_result u_result (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .frame_i     (frame),
    .crc_byte_i  (in_byte_q),
    .family_i    (family_q),
    .out_ready_i (m_axis_tready),
    .slot_free_o (slot_free),
    .out_valid_o (m_axis_tvalid),
    .temp_o      (temp),
    .crc_ok_o    (crc_ok),
    .crc_o       (crc)
  );

  assign m_axis_tdata = {crc, temp};
  assign m_axis_tuser = crc_ok;

  // a result is only loaded into a free slot
  a_load_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> (!m_axis_tvalid || m_axis_tready))
    else $error("result loaded over a pending result");

  // a loaded result is offered in the next cycle
  a_load_offered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> m_axis_tvalid)
    else $error("loaded result not offered");

  // an empty input register always takes a byte
  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_q |-> s_axis_tready)
    else $error("input stalled while empty");

  // a failed CRC reports a zero temperature
  a_bad_crc_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[15:0] == '0))
    else $error("nonzero temperature with bad CRC");

endmodule

### rtl/tsd_frame.sv
// Frame tracker: byte position counter, running CRC-8 and captured scratchpad fields.
// Depends on tsd_pkg.
module tsd_frame (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        step_i,
  input  logic [tsd_pkg::ByteW-1:0]   byte_i,
  input  logic                        start_i,
  output logic                        final_o,
  output tsd_pkg::tsd_frame_t         frame_o
);
  import tsd_pkg::*;

  localparam logic [ByteW-1:0] CrcPoly = 8'h8C;

  // Reflected CRC-8, one byte per call (eight narrow bit steps)
  function automatic logic [ByteW-1:0] crc8_update(input logic [ByteW-1:0] crc_in,
                                                   input logic [ByteW-1:0] data_in);
    logic [ByteW-1:0] c;
    logic [ByteW-1:0] d;
    logic             mix;
    c = crc_in;
    d = data_in;
    for (int b = 0; b < ByteW; b++) begin
      mix = c[0] ^ d[0];
      c   = {1'b0, c[ByteW-1:1]};
      if (mix) begin
        c = c ^ CrcPoly;
      end
      d = {1'b0, d[ByteW-1:1]};
    end
    return c;
  endfunction

  logic [PosW-1:0]  pos_q, pos_d;
  logic [ByteW-1:0] crc_q, crc_d;
  logic [ByteW-1:0] lo_q, hi_q, res_q, cr_q, cpd_q;
  logic [PosW-1:0]  pos_eff;
  logic [ByteW-1:0] crc_eff;

  // frame_start restarts the count and the CRC
  assign pos_eff = start_i ? PosTempLo : pos_q;
  assign crc_eff = start_i ? '0 : crc_q;
  assign final_o = (pos_eff >= PosCrc);

  // next position and CRC
  always_comb begin
    pos_d = pos_q;
    crc_d = crc_q;
    if (step_i) begin
      if (final_o) begin
        pos_d = PosTempLo;
        crc_d = '0;
      end else begin
        pos_d = pos_eff + 4'd1;
        crc_d = crc8_update(crc_eff, byte_i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= PosTempLo;
      crc_q <= '0;
    end else begin
      pos_q <= pos_d;
      crc_q <= crc_d;
    end
  end

  // field capture, no reset needed
  always_ff @(posedge clk_i) begin
    if (step_i && !final_o) begin
      case (pos_eff)
        PosTempLo:      lo_q  <= byte_i;
        PosTempHi:      hi_q  <= byte_i;
        PosResolution:  res_q <= byte_i;
        PosCountRemain: cr_q  <= byte_i;
        PosCountPerDeg: cpd_q <= byte_i;
        default: ;
      endcase
    end
  end

  assign frame_o.crc              = crc_q;
  assign frame_o.temp_lo          = lo_q;
  assign frame_o.temp_hi          = hi_q;
  assign frame_o.resolution       = res_q;
  assign frame_o.count_remain     = cr_q;
  assign frame_o.count_per_degree = cpd_q;

endmodule

### rtl/tsd_result.sv
// Result stage: CRC check, temperature conversion and the output register.
// Depends on tsd_pkg.
module tsd_result (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        load_i,
  input  tsd_pkg::tsd_frame_t         frame_i,
  input  logic [tsd_pkg::ByteW-1:0]   crc_byte_i,
  input  logic [tsd_pkg::ByteW-1:0]   family_i,
  input  logic                        out_ready_i,
  output logic                        slot_free_o,
  output logic                        out_valid_o,
  output logic [tsd_pkg::TempW-1:0]   temp_o,
  output logic                        crc_ok_o,
  output logic [tsd_pkg::ByteW-1:0]   crc_o
);
  import tsd_pkg::*;

  localparam logic [ByteW-1:0] FamilyOld         = 8'h10;
  localparam logic [ByteW-1:0] FullCountPerDeg   = 8'h10;
  localparam logic [TempW-1:0] CountRemainOffset = 16'd12;
  localparam logic [TempW-1:0] MaskDegree        = 16'hFFF0;
  localparam logic [1:0]       Res9Bit           = 2'b00;
  localparam logic [1:0]       Res10Bit          = 2'b01;
  localparam logic [1:0]       Res11Bit          = 2'b10;

  logic             valid_q;
  logic [TempW-1:0] temp_q, temp_d;
  logic             ok_q, ok_d;
  logic [ByteW-1:0] crc_q;
  logic [TempW-1:0] raw;
  logic [TempW-1:0] shifted;
  logic [TempW-1:0] conv;

  assign slot_free_o = !valid_q || out_ready_i;

  // temperature conversion, 16-bit wrap
  always_comb begin
    raw     = {frame_i.temp_hi, frame_i.temp_lo};
    shifted = {raw[TempW-4:0], 3'b000};
    conv    = raw;
    if (family_i == FamilyOld) begin
      if (frame_i.count_per_degree == FullCountPerDeg) begin
        conv = (shifted & MaskDegree) + CountRemainOffset
               - {{(TempW-ByteW){1'b0}}, frame_i.count_remain};
      end else begin
        conv = shifted;
      end
    end else begin
      case (frame_i.resolution[6:5])
        Res9Bit:  conv = raw & 16'hFFF8;
        Res10Bit: conv = raw & 16'hFFFC;
        Res11Bit: conv = raw & 16'hFFFE;
        default:  conv = raw;
      endcase
    end
    ok_d   = (frame_i.crc == crc_byte_i);
    temp_d = ok_d ? conv : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      temp_q <= temp_d;
      ok_q   <= ok_d;
      crc_q  <= frame_i.crc;
    end
  end

  assign out_valid_o = valid_q;
  assign temp_o      = temp_q;
  assign crc_ok_o    = ok_q;
  assign crc_o       = crc_q;

endmodule

### sim/temp_sensor_scratchpad_decoder_tb.sv
// Self-checking testbench for temp_sensor_scratchpad_decoder: scratchpad frames in,
// decoded readings checked against a cycle-free predictor of the decode.
// Depends on tsd_pkg and the RTL of the decoder.
`timescale 1ns / 1ps

module temp_sensor_scratchpad_decoder_tb;
  import tsd_pkg::*;

  localparam int unsigned CycleLimit    = 200000;
  localparam int unsigned SettleCycles  = 6;
  localparam int unsigned PhaseItems    = 89;
  localparam int unsigned NumPhases     = 9;

  localparam logic [7:0] CrcPoly         = 8'h8C;
  localparam logic [7:0] OldFamily       = 8'h10;
  localparam logic [7:0] FullCountPerDeg = 8'h10;
  localparam logic [7:0] ResetFamily     = 8'h28;

  // Resolution bits 6:5 of the config byte
  localparam logic [1:0] Res9Bit  = 2'b00;
  localparam logic [1:0] Res10Bit = 2'b01;
  localparam logic [1:0] Res11Bit = 2'b10;

  typedef struct {
    logic [7:0] data;
    logic       start;
  } sp_byte_t;

  typedef struct {
    logic [15:0] temp;
    logic        ok;
    logic [7:0]  crc;
  } reading_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_wr_en_i;
  logic [7:0]  cfg_wr_data_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [7:0] data_byte
  logic        s_axis_tuser;   // [0] frame_start
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;   // [15:0] temperature_sixteenths, [23:16] computed_crc
  logic        m_axis_tuser;   // [0] crc_ok

  sp_byte_t    pending_bytes[$];
  reading_t    expected_readings[$];
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned error_count;
  int unsigned cycle_count;
  logic        byte_fire;

  // Predictor state
  logic [3:0]  pos_q;
  logic [7:0]  crc_q;
  logic [7:0]  temp_lo_q;
  logic [7:0]  temp_hi_q;
  logic [7:0]  res_q;
  logic [7:0]  count_remain_q;
  logic [7:0]  count_per_deg_q;
  logic [7:0]  family_q;

  temp_sensor_scratchpad_decoder u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_wr_data_i (cfg_wr_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // 8 ns clock
  initial clk_i = 1'b0;
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Dallas/Maxim CRC-8, LSB first
  function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    logic [7:0] d;
    logic       mix;
    c = crc;
    d = b;
    for (int i = 0; i < 8; i++) begin
      mix = c[0] ^ d[0];
      c = c >> 1;
      if (mix) c = c ^ CrcPoly;
      d = d >> 1;
    end
    return c;
  endfunction

  // Temperature in sixteenths from the captured bytes, 16-bit wrap
  function automatic logic [15:0] temp_sixteenths();
    logic [15:0] raw;
    raw = {temp_hi_q, temp_lo_q};
    if (family_q == OldFamily) begin
      raw = raw << 3;
      if (count_per_deg_q == FullCountPerDeg)
        raw = (raw & 16'hFFF0) + 16'd12 - {8'h00, count_remain_q};
    end else begin
      case (res_q[6:5])
        Res9Bit:  raw = raw & 16'hFFF8;
        Res10Bit: raw = raw & 16'hFFFC;
        Res11Bit: raw = raw & 16'hFFFE;
        default:  raw = raw;
      endcase
    end
    return raw;
  endfunction

  // Queue one full frame; the check byte is right or deliberately wrong
  task automatic add_frame(input logic [7:0] lo, input logic [7:0] hi, input logic [7:0] res,
                           input logic [7:0] rem, input logic [7:0] cpd,
                           input bit mark_start, input bit crc_good);
    logic [7:0] bytes[8];
    logic [7:0] crc;
    sp_byte_t   item;
    bytes = '{lo, hi, 8'($urandom), 8'($urandom), res, 8'($urandom), rem, cpd};
    crc = 8'h00;
    for (int i = 0; i < 8; i++) begin
      crc = crc8_next(crc, bytes[i]);
      item.data  = bytes[i];
      item.start = (i == 0) && mark_start;
      pending_bytes.push_back(item);
    end
    item.data  = crc_good ? crc : crc ^ 8'($urandom_range(1, 255));
    item.start = 1'b0;
    pending_bytes.push_back(item);
  endtask

  // Queue n bytes with random content; start flag on the first one or at random
  task automatic add_loose_bytes(input int n, input bit first_start, input int start_pct);
    sp_byte_t item;
    for (int i = 0; i < n; i++) begin
      item.data  = 8'($urandom);
      item.start = (i == 0 && first_start) || ($urandom_range(0, 99) < start_pct);
      pending_bytes.push_back(item);
    end
  endtask

  // Mostly well-formed frames, some truncated frames and some stray bytes
  task automatic add_random_items(input int unsigned n_items);
    int unsigned target;
    int unsigned pick;
    logic [7:0]  cpd;
    target = pending_bytes.size() + n_items;
    while (pending_bytes.size() < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
        cpd = ($urandom_range(0, 1) != 0) ? FullCountPerDeg : 8'($urandom);
        add_frame(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom_range(0, 20)) |
                  (($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'h00), cpd,
                  $urandom_range(0, 99) < 80, $urandom_range(0, 99) < 85);
      end else if (pick < 88) begin
        add_loose_bytes($urandom_range(1, 7), 1'b1, 0);
      end else begin
        add_loose_bytes($urandom_range(1, 6), 1'b0, 20);
      end
    end
  endtask

  task automatic write_family(input logic [7:0] value);
    @(negedge clk_i);
    cfg_wr_en_i   <= 1'b1;
    cfg_wr_data_i <= value;
    @(negedge clk_i);
    cfg_wr_en_i   <= 1'b0;
  endtask

  // Block until every byte is sent and every reading has come, then let it settle;
  // checked at the rising edge, where the driven inputs are stable
  task automatic wait_idle();
    @(posedge clk_i);
    while (pending_bytes.size() != 0 || s_axis_tvalid || expected_readings.size() != 0)
      @(posedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic set_idle_mode(input int unsigned mode);
    case (mode)
      0: begin send_idle_pct = 35; recv_idle_pct = 58; end
      1: begin send_idle_pct = 58; recv_idle_pct = 35; end
      default: begin send_idle_pct = 0; recv_idle_pct = 0; end
    endcase
  endtask

  // Byte driver: next byte after a transfer or while idle
  always @(negedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid || byte_fire)) begin
      if (pending_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pending_bytes[0].data;
        s_axis_tuser  <= pending_bytes[0].start;
        void'(pending_bytes.pop_front());
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Reading receiver back-pressure
  always @(negedge clk_i) begin
    if (rst_ni) m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Monitor: predict on byte transfers, check on reading transfers
  always @(posedge clk_i or negedge rst_ni) begin
    reading_t exp_r;
    if (!rst_ni) begin
      byte_fire       <= 1'b0;
      pos_q           = '0;
      crc_q           = '0;
      temp_lo_q       = '0;
      temp_hi_q       = '0;
      res_q           = '0;
      count_remain_q  = '0;
      count_per_deg_q = '0;
      family_q        = ResetFamily;
    end else begin
      byte_fire <= s_axis_tvalid && s_axis_tready;
      if (cfg_wr_en_i) family_q = cfg_wr_data_i;

      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_readings.size() == 0) begin
          $display("%0t: unexpected reading, actual temp %h crc %h ok %b", $time,
                   m_axis_tdata[15:0], m_axis_tdata[23:16], m_axis_tuser);
          error_count++;
        end else begin
          exp_r = expected_readings.pop_front();
          if (m_axis_tdata[15:0] !== exp_r.temp) begin
            $display("%0t: temperature mismatch, expected %h, actual %h", $time,
                     exp_r.temp, m_axis_tdata[15:0]);
            error_count++;
          end
          if (m_axis_tdata[23:16] !== exp_r.crc) begin
            $display("%0t: computed crc mismatch, expected %h, actual %h", $time,
                     exp_r.crc, m_axis_tdata[23:16]);
            error_count++;
          end
          if (m_axis_tuser !== exp_r.ok) begin
            $display("%0t: crc_ok mismatch, expected %b, actual %b", $time,
                     exp_r.ok, m_axis_tuser);
            error_count++;
          end
        end
      end

      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser) begin
          pos_q = PosTempLo;
          crc_q = 8'h00;
        end
        if (pos_q < PosCrc) begin
          case (pos_q)
            PosTempLo:      temp_lo_q       = s_axis_tdata;
            PosTempHi:      temp_hi_q       = s_axis_tdata;
            PosResolution:  res_q           = s_axis_tdata;
            PosCountRemain: count_remain_q  = s_axis_tdata;
            PosCountPerDeg: count_per_deg_q = s_axis_tdata;
            default: ;
          endcase
          crc_q = crc8_next(crc_q, s_axis_tdata);
          pos_q = pos_q + 4'd1;
        end else begin
          exp_r.ok   = (crc_q == s_axis_tdata);
          exp_r.temp = exp_r.ok ? temp_sixteenths() : 16'h0000;
          exp_r.crc  = crc_q;
          expected_readings.push_back(exp_r);
          pos_q = PosTempLo;
          crc_q = 8'h00;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Sequence: reset, directed frames, then random phases over several family codes
  initial begin
    logic [7:0] phase_family[NumPhases];
    rst_ni        = 1'b0;
    cfg_wr_en_i   = 1'b0;
    cfg_wr_data_i = 8'h00;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 8'h00;
    s_axis_tuser  = 1'b0;
    m_axis_tready = 1'b0;
    error_count   = 0;
    cycle_count   = 0;
    phase_family  = '{OldFamily, 8'h00, 8'hFF, OldFamily, 8'($urandom), OldFamily,
                      ResetFamily, 8'($urandom), OldFamily};
    set_idle_mode(0);
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: extremes at reset family, truncated frame restart, bad check byte,
    // and a frame that follows the previous one with no start flag
    add_frame(8'hFF, 8'hFF, {1'b0, Res10Bit, 5'h1F}, 8'h00, FullCountPerDeg, 1'b1, 1'b1);
    add_loose_bytes(3, 1'b1, 0);
    add_frame(8'hFF, 8'h7F, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b0);
    add_frame(8'h00, 8'h80, {1'b0, Res11Bit, 5'h00}, 8'h0C, 8'h00, 1'b0, 1'b1);
    wait_idle();

    for (int p = 0; p < NumPhases; p++) begin
      set_idle_mode(p * 3 / NumPhases);
      write_family(phase_family[p]);
      add_random_items(PhaseItems);
      wait_idle();
    end

    if (error_count == 0 && expected_readings.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
